### rtl/rktc_pkg.sv
`timescale 1ns / 1ps

package rktc_pkg;

  localparam int KEY_W             = 64;
  localparam int COUNT_W           = 16;
  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd10;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_SCAN    = 1'b1;

  typedef struct packed {
    logic             scan;
    logic             absent;
    logic [KEY_W-1:0] upper;
    logic [KEY_W-1:0] lower;
  } item_t;

  typedef struct packed {
    logic             absent;
    logic [KEY_W-1:0] upper;
    logic [KEY_W-1:0] lower;
  } key_t;

endpackage

### rtl/rktc_front.sv
`timescale 1ns / 1ps

module rktc_front
  import rktc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             operation,
  input  logic [KEY_W-1:0] key_upper,
  input  logic [KEY_W-1:0] key_lower,
  input  logic             key_absent,
  output logic             busy,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           push;
  item_t          item_in;

  // absent keys travel with zero key bits
  always_comb begin
    item_in.scan   = (operation == OP_SCAN);
    item_in.absent = key_absent;
    item_in.upper  = key_absent ? '0 : key_upper;
    item_in.lower  = key_absent ? '0 : key_lower;
  end

  assign busy    = (fill == QCW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/rktc_back.sv
`timescale 1ns / 1ps

module rktc_back
  import rktc_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] threshold,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               done,
  output logic               attack_flag,
  output logic               matched_entry,
  output logic               stored_new,
  output logic               dropped_full,
  output logic [COUNT_W-1:0] occurrence_count
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SRCH = 2'b10
  } state_t;

  state_t state;

  key_t               key_mem [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];

  item_t              cur;
  logic [CW-1:0]      used;
  logic [CW-1:0]      ptr;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_idx;
  key_t               rd_key;
  logic [COUNT_W-1:0] rd_cnt;

  logic               issue;
  logic               hit;
  logic               miss;
  logic               room;
  logic [COUNT_W-1:0] cnt_next;
  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               key_we;
  key_t               key_wdata;

  assign issue = (ptr < used);
  assign room  = (used < CW'(TABLE_ENTRIES));
  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    if (rd_key.absent) begin
      hit = cmp_vld && cur.absent;
    end else begin
      hit = cmp_vld && !cur.absent && (rd_key.upper == cur.upper)
            && (rd_key.lower == cur.lower);
    end
  end

  assign miss     = !hit && !issue;
  assign cnt_next = (rd_cnt != COUNT_MAX) ? rd_cnt + 1'b1 : rd_cnt;

  always_comb begin
    key_wdata.absent = cur.absent;
    key_wdata.upper  = cur.upper;
    key_wdata.lower  = cur.lower;
    key_we    = (state == ST_SRCH) && miss && room;
    cnt_we    = 1'b0;
    cnt_waddr = used[AW-1:0];
    cnt_wdata = COUNT_W'(1);
    if (state == ST_SRCH) begin
      if (hit) begin
        cnt_we    = 1'b1;
        cnt_waddr = cmp_idx;
        cnt_wdata = cnt_next;
      end else if (miss && room) begin
        cnt_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[used[AW-1:0]] <= key_wdata;
    end
    rd_key <= key_mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    rd_cnt <= cnt_mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    cmp_idx <= ptr[AW-1:0];
    if (q_pop) begin
      cur <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      used    <= '0;
      ptr     <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= (state == ST_SRCH) && issue;
      unique case (state)
        ST_IDLE: begin
          ptr <= '0;
          if (q_pop) begin
            if (q_item.scan) begin
              used             <= '0;
              done             <= 1'b1;
              attack_flag      <= 1'b0;
              matched_entry    <= 1'b0;
              stored_new       <= 1'b0;
              dropped_full     <= 1'b0;
              occurrence_count <= '0;
            end else begin
              state <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (hit) begin
            state            <= ST_IDLE;
            done             <= 1'b1;
            attack_flag      <= (rd_cnt != COUNT_MAX) && !cur.absent
                                && (cnt_next == threshold);
            matched_entry    <= 1'b1;
            stored_new       <= 1'b0;
            dropped_full     <= 1'b0;
            occurrence_count <= cnt_next;
          end else if (miss) begin
            state         <= ST_IDLE;
            done          <= 1'b1;
            attack_flag   <= 1'b0;
            matched_entry <= 1'b0;
            stored_new    <= room;
            dropped_full  <= !room;
            if (room) begin
              used             <= used + 1'b1;
              occurrence_count <= COUNT_W'(1);
            end else begin
              occurrence_count <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/repeated_key_threshold_counter.sv
`timescale 1ns / 1ps

// Counts repeated 128-bit service keys (an absent key is a key of its own) in
// a table of TABLE_ENTRIES entries and flags a present key whose count reaches
// alarm_threshold on a match. Items are taken on start while busy is low into a
// two-item queue; busy rises only when that queue is full. A scan-start item
// gives its result in the cycle after it leaves the queue; an observe item
// walks the used entries one per cycle through the table memory's single read
// port, stops at the first match and gives its result once it matches or has
// passed every used entry. Each result is shown for one cycle with done high
// and cannot be held off, so it must be taken in that cycle.
module repeated_key_threshold_counter
  import rktc_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               alarm_threshold_we,
  input  logic [COUNT_W-1:0] alarm_threshold_data,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [KEY_W-1:0]   key_upper,
  input  logic [KEY_W-1:0]   key_lower,
  input  logic               key_absent,
  output logic               done,
  output logic               attack_flag,
  output logic               matched_entry,
  output logic               stored_new,
  output logic               dropped_full,
  output logic [COUNT_W-1:0] occurrence_count
);

  logic [COUNT_W-1:0] alarm_threshold;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_threshold <= THRESHOLD_RESET;
    end else if (alarm_threshold_we) begin
      alarm_threshold <= alarm_threshold_data;
    end
  end

  rktc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .key_upper  (key_upper),
    .key_lower  (key_lower),
    .key_absent (key_absent),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rktc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .threshold        (alarm_threshold),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .done             (done),
    .attack_flag      (attack_flag),
    .matched_entry    (matched_entry),
    .stored_new       (stored_new),
    .dropped_full     (dropped_full),
    .occurrence_count (occurrence_count)
  );

  a_busy_after_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy high right after reset");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({matched_entry, stored_new, dropped_full}))
    else $error("more than one outcome in a result beat");

  a_attack_on_match: assert property (@(posedge clk) disable iff (rst)
    done && attack_flag |-> matched_entry && (occurrence_count == alarm_threshold))
    else $error("attack flagged without a match at threshold");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    done && stored_new |-> occurrence_count == COUNT_W'(1))
    else $error("new entry with count other than one");

endmodule
